// File: rtl/eam_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the exclusive monitor / atomic unit.
// No dependencies; imported by every other file in rtl/.
package eam_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDEF = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;

    // Encoding group: bits 29:24 of the instruction word
    localparam logic [5:0] GROUP_CODE = 6'b001000;

    // Zero register number
    localparam logic [4:0] REG_ZR = 5'd31;

    // Access sizes in bytes
    localparam logic [4:0] BYTES_PAIR_W = 5'd8;
    localparam logic [4:0] BYTES_PAIR_X = 5'd16;

    typedef struct packed {
        logic [31:0] instruction;
        logic [63:0] base_address;
        logic [63:0] compare_value;
        logic [63:0] compare_value_high;
        logic [63:0] data_value;
        logic [63:0] data_value_second;
        logic [63:0] memory_first;
        logic [63:0] memory_second;
    } t_eam_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        memory_write;
        logic [63:0] write_first;
        logic [63:0] write_second;
        logic [4:0]  access_size_bytes;
        logic        reg_a_write;
        logic [4:0]  reg_a_index;
        logic [63:0] reg_a_value;
        logic        reg_b_write;
        logic [4:0]  reg_b_index;
        logic [63:0] reg_b_value;
    } t_eam_out;

    // Monitor contents
    typedef struct packed {
        logic        valid;
        logic [63:0] address;
        logic [4:0]  size;
        logic [63:0] first;
        logic [63:0] second;
    } t_eam_mon;

    // Monitor update request from the execute logic
    typedef struct packed {
        logic        set;
        logic        clr;
        logic [63:0] address;
        logic [4:0]  size;
        logic [63:0] first;
        logic [63:0] second;
    } t_eam_upd;

    // Element mask for a log2 byte size
    function automatic logic [63:0] eam_mask(input logic [1:0] lg);
        logic [63:0] m;
        begin
            case (lg)
                2'd0:    m = 64'h0000_0000_0000_00FF;
                2'd1:    m = 64'h0000_0000_0000_FFFF;
                2'd2:    m = 64'h0000_0000_FFFF_FFFF;
                default: m = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            return m;
        end
    endfunction

    // True when the low address bits are not a multiple of the total size
    function automatic logic eam_misaligned(input logic [3:0] addr_lo,
                                            input logic [4:0] total);
        logic [4:0] lim;
        begin
            lim = total - 5'd1;
            return (addr_lo & lim[3:0]) != 4'd0;
        end
    endfunction

endpackage

// File: rtl/eam_exec.sv
`timescale 1ns / 1ps
// Decode and execute logic for one instruction: status, memory write, register writes
// and the monitor update request. Purely combinational; depends on eam_pkg.
module eam_exec (
    input  eam_pkg::t_eam_in  i_item,
    input  eam_pkg::t_eam_mon i_mon,
    output eam_pkg::t_eam_out o_res,
    output eam_pkg::t_eam_upd o_upd
);
    import eam_pkg::*;

    logic [31:0] insn;
    logic [4:0]  rt, rt2, rs, rs_hi;
    logic [1:0]  sz;
    logic        o2, ld, o1, in_group;
    logic [4:0]  bytes, casp_total, excl_total;
    logic [63:0] m, em;
    logic [63:0] old_lo, old_hi, ex_hi;
    logic [3:0]  addr_lo;
    t_eam_out    res;
    t_eam_upd    upd;

    assign insn       = i_item.instruction;
    assign rt         = insn[4:0];
    assign rt2        = insn[14:10];
    assign rs         = insn[20:16];
    assign rs_hi      = rs + 5'd1;
    assign sz         = insn[31:30];
    assign o2         = insn[23];
    assign ld         = insn[22];
    assign o1         = insn[21];
    assign in_group   = (insn[29:24] == GROUP_CODE);
    assign bytes      = 5'd1 << sz;
    assign m          = eam_mask(sz);
    assign em         = eam_mask({1'b1, insn[30]});
    assign casp_total = insn[30] ? BYTES_PAIR_X : BYTES_PAIR_W;
    assign excl_total = o1 ? {bytes[3:0], 1'b0} : bytes;
    assign addr_lo    = i_item.base_address[3:0];
    assign old_lo     = i_item.memory_first & m;
    assign old_hi     = i_item.memory_second & em;
    assign ex_hi      = o1 ? (i_item.memory_second & m) : 64'd0;

    always_comb begin
        res        = '0;
        res.status = ST_UNDEF;
        upd        = '0;
        if (in_group) begin
            if (o2 && o1) begin
                // CAS
                if (rt2 == REG_ZR) begin
                    res.access_size_bytes = bytes;
                    if (eam_misaligned(addr_lo, bytes)) begin
                        res.status = ST_ALIGN;
                    end else begin
                        res.status = ST_OK;
                        if (old_lo == (i_item.compare_value & m)) begin
                            res.memory_write = 1'b1;
                            res.write_first  = i_item.data_value & m;
                        end
                        if (rs != REG_ZR) begin
                            res.reg_a_write = 1'b1;
                            res.reg_a_index = rs;
                            res.reg_a_value = old_lo;
                        end
                    end
                end
            end else if (o2) begin
                // LDAR / STLR, no alignment check
                if (rs == REG_ZR && rt2 == REG_ZR) begin
                    res.status            = ST_OK;
                    res.access_size_bytes = bytes;
                    if (ld) begin
                        if (rt != REG_ZR) begin
                            res.reg_a_write = 1'b1;
                            res.reg_a_index = rt;
                            res.reg_a_value = old_lo;
                        end
                    end else begin
                        res.memory_write = 1'b1;
                        res.write_first  = i_item.data_value & m;
                    end
                end
            end else if (o1 && !insn[31]) begin
                // CASP
                if (rt2 == REG_ZR && !rs[0] && !rt[0]) begin
                    res.access_size_bytes = casp_total;
                    if (eam_misaligned(addr_lo, casp_total)) begin
                        res.status = ST_ALIGN;
                    end else begin
                        res.status = ST_OK;
                        if (((i_item.memory_first & em) == (i_item.compare_value & em)) &&
                            (old_hi == (i_item.compare_value_high & em))) begin
                            res.memory_write = 1'b1;
                            res.write_first  = i_item.data_value & em;
                            res.write_second = i_item.data_value_second & em;
                        end
                        if (rs != REG_ZR) begin
                            res.reg_a_write = 1'b1;
                            res.reg_a_index = rs;
                            res.reg_a_value = i_item.memory_first & em;
                        end
                        if (rs_hi != REG_ZR) begin
                            res.reg_b_write = 1'b1;
                            res.reg_b_index = rs_hi;
                            res.reg_b_value = old_hi;
                        end
                    end
                end
            end else if (ld) begin
                // LDXR / LDXP
                if (rs == REG_ZR && (o1 || rt2 == REG_ZR)) begin
                    res.access_size_bytes = excl_total;
                    if (eam_misaligned(addr_lo, excl_total)) begin
                        res.status = ST_ALIGN;
                    end else begin
                        res.status  = ST_OK;
                        upd.set     = 1'b1;
                        upd.address = i_item.base_address;
                        upd.size    = excl_total;
                        upd.first   = old_lo;
                        upd.second  = ex_hi;
                        if (rt != REG_ZR) begin
                            res.reg_a_write = 1'b1;
                            res.reg_a_index = rt;
                            res.reg_a_value = old_lo;
                        end
                        if (o1 && rt2 != REG_ZR) begin
                            res.reg_b_write = 1'b1;
                            res.reg_b_index = rt2;
                            res.reg_b_value = ex_hi;
                        end
                    end
                end
            end else begin
                // STXR / STXP
                if (o1 || rt2 == REG_ZR) begin
                    res.access_size_bytes = excl_total;
                    if (eam_misaligned(addr_lo, excl_total)) begin
                        res.status = ST_ALIGN;
                    end else begin
                        res.status = ST_OK;
                        upd.clr    = 1'b1;
                        if (i_mon.valid && i_mon.address == i_item.base_address &&
                            i_mon.size == excl_total && old_lo == i_mon.first &&
                            (!o1 || ex_hi == i_mon.second)) begin
                            res.memory_write = 1'b1;
                            res.write_first  = i_item.data_value & m;
                            res.write_second = o1 ? (i_item.data_value_second & m) : 64'd0;
                        end
                        if (rs != REG_ZR) begin
                            res.reg_a_write = 1'b1;
                            res.reg_a_index = rs;
                            res.reg_a_value = {63'd0, !res.memory_write};
                        end
                    end
                end
            end
        end
    end

    assign o_res = res;
    assign o_upd = upd;

endmodule

// File: rtl/eam_monitor.sv
`timescale 1ns / 1ps
// One-entry exclusive monitor: address, total size and the values seen by the last
// load-exclusive. Depends on eam_pkg.
module eam_monitor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  eam_pkg::t_eam_upd i_upd,
    output eam_pkg::t_eam_mon o_mon
);
    import eam_pkg::*;

    t_eam_mon r_mon;
    t_eam_mon n_mon;

    always_comb begin
        n_mon = r_mon;
        if (i_en) begin
            if (i_upd.set) begin
                n_mon.valid   = 1'b1;
                n_mon.address = i_upd.address;
                n_mon.size    = i_upd.size;
                n_mon.first   = i_upd.first;
                n_mon.second  = i_upd.second;
            end else if (i_upd.clr) begin
                n_mon.valid = 1'b0;
            end
        end
    end

    // Only the valid flag needs a reset; the rest is read only while valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mon.valid <= 1'b0;
        end else begin
            r_mon.valid <= n_mon.valid;
        end
        r_mon.address <= n_mon.address;
        r_mon.size    <= n_mon.size;
        r_mon.first   <= n_mon.first;
        r_mon.second  <= n_mon.second;
    end

    assign o_mon = r_mon;

endmodule

// File: rtl/exclusive_monitor_atomic_unit_core.sv
`timescale 1ns / 1ps
// Exclusive monitor and atomic unit for the load/store-exclusive instruction group.
// Top level: input register, eam_exec, eam_monitor and the result register; uses eam_pkg.
//
// Usage
//   Input channel  : i_in_valid / o_in_stall / i_in_data. One transfer carries one
//                    instruction word with its base address, source register values
//                    and the current memory contents.
//   Output channel : o_out_valid / i_out_stall / o_out_data. One transfer per input
//                    transfer, in order: status, memory write and up to two register
//                    writes.
//   Path           : the result is registered in the input register and then in the result
//                    register before it is offered; an output stall holds it in place.
//   Throughput     : one instruction per cycle unless the output stalls. Decode, compare and
//                    monitor update sit in one short stage between the two registers.
//   Monitor        : updated at the edge where an instruction moves into the result
//                    register, so the next instruction always sees its effect.
//   Reset          : synchronous, active low; empties both registers and invalidates
//                    the monitor. No clearing pass is needed.
//   Stall          : while the result register is held, the input register holds its
//                    instruction and o_in_stall rises only if that register is full.
module exclusive_monitor_atomic_unit_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  eam_pkg::t_eam_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output eam_pkg::t_eam_out o_out_data
);
    import eam_pkg::*;

    logic     r_in_valid;
    logic     n_in_valid;
    t_eam_in  r_in_data;
    logic     r_out_valid;
    logic     n_out_valid;
    t_eam_out r_out_data;

    logic     w_adv;     // input register may advance into the result register
    logic     w_load;    // new transfer enters the input register
    t_eam_out w_res;
    t_eam_upd w_upd;
    t_eam_mon w_mon;

    // Advance whenever the result register is empty or being drained
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_load     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = r_in_valid;
            n_in_valid  = 1'b0;
        end
        if (w_load) begin
            n_in_valid = 1'b1;
        end
    end

    eam_exec u_exec (
        .i_item (r_in_data),
        .i_mon  (w_mon),
        .o_res  (w_res),
        .o_upd  (w_upd)
    );

    // Commit monitor changes only when the instruction actually retires into the result
    eam_monitor u_monitor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv && r_in_valid),
        .i_upd   (w_upd),
        .o_mon   (w_mon)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_data <= i_in_data;
        end
        if (w_adv && r_in_valid) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A memory write only accompanies a completed instruction
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.memory_write |-> o_out_data.status == ST_OK)
        else $error("memory write on a non-completed result");

    // The zero register is never written
    a_no_zr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.reg_a_write && o_out_data.reg_a_index == REG_ZR) &&
                        !(o_out_data.reg_b_write && o_out_data.reg_b_index == REG_ZR))
        else $error("write to zero register");

    // Input stalls only when both registers are full and the receiver stalls
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without back-pressure");

    // A successful store-exclusive needs a live monitor, and leaves it cleared
    a_stx_mon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_valid && w_upd.clr && w_res.memory_write |-> w_mon.valid ##1 !w_mon.valid)
        else $error("store-exclusive monitor handling broken");

endmodule
